[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define FCA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, switched off while reset is held.
`define FCA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

[sv/fca_pkg.sv]
// ----------------------------------------------------------------------------
// fca_pkg
// Types and constants of the first-fit contiguous slot allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int SLOTS_DEFAULT = 16384;
    localparam int WORD_BITS     = 64;
    localparam int REQ_W         = 15;
    localparam int START_W       = 14;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_CHECK,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_RESP
    } state_t;

endpackage

[sv/first_fit_contiguous_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator
// Bitmap allocator returning the lowest free run of the requested length.
// ----------------------------------------------------------------------------
// Each input item on the s_ channel asks for request_size contiguous slots.
// The block answers each item with exactly one result item on the m_ channel:
// m_tuser is the grant flag and m_tdata the first slot of the run (zero when
// nothing was granted). A granted run is marked used; there is no release.
// The occupancy bitmap sits in a memory of 64-bit words, one word read or
// written per cycle. After reset a clearing pass writes every word to zero;
// s_tready stays low until it ends. A request is then accepted in the idle
// state. Each word is read and checked; a word that is wholly used, or
// skipped as wholly free, moves the search on, and any other word is walked
// eight slots at a time. Each word that the granted run covers is read and
// written back with its slots marked, and the result is then handed over.
// A new item is taken while the previous result still waits in the output
// register; the block then holds its result until m_tready frees that
// register, and s_tready stays low from acceptance until then.
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator #(
    parameter int SLOTS = fca_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [14:0] request_size, [15] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [13:0] start_slot, [15:14] zero
    output logic        m_tuser    // [0] granted
);

    localparam int WB     = fca_pkg::WORD_BITS;
    localparam int RW     = fca_pkg::REQ_W;
    localparam int WORDS  = (SLOTS + WB - 1) / WB;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_W = AW + 6;
    localparam int FW     = (SLOT_W > fca_pkg::START_W) ? SLOT_W : fca_pkg::START_W;
    localparam int REM    = SLOTS % WB;
    localparam logic [AW-1:0] LAST = AW'(WORDS - 1);
    localparam logic [WB-1:0] PAD  = (REM == 0) ? '0 : ~((64'd1 << REM) - 64'd1);

    fca_pkg::state_t state_reg, state_next;

    logic [WB-1:0]     mem [WORDS];
    logic [WB-1:0]     mem_q;
    logic              mem_we, mem_re;
    logic [WB-1:0]     mem_wdata;

    logic [AW-1:0]     word_reg;
    logic [2:0]        byte_reg;
    logic [RW-1:0]     run_reg, size_reg;
    logic [SLOT_W-1:0] first_reg, end_reg;
    logic              grant_reg;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;
    logic              m_tuser_reg;

    logic [WB-1:0]     eff_word;
    logic [7:0]        cur_byte;
    logic              all_used, skip_word, last_word;
    logic              req_bad, out_free;
    logic              hit;
    logic [2:0]        hit_pos;
    logic [RW-1:0]     run_after;
    logic [SLOT_W-1:0] end_slot, first_slot;
    logic [5:0]        mark_lo, mark_hi;
    logic [WB-1:0]     mark_mask;
    logic [RW:0]       run_plus;
    logic [FW-1:0]     first_ext;

    always_comb begin
        eff_word  = mem_q | ((word_reg == LAST) ? PAD : '0);
        cur_byte  = eff_word[byte_reg*8 +: 8];
        last_word = (word_reg == LAST);
        all_used  = &eff_word;
        run_plus  = {1'b0, run_reg} + (RW+1)'(WB);
        skip_word = (eff_word == '0) && (run_plus < {1'b0, size_reg});
        req_bad   = (s_tdata[RW-1:0] == '0) || (32'(s_tdata[RW-1:0]) > SLOTS);
        out_free  = !m_tvalid_reg || m_tready;
    end

    // Walk one byte of the current word, counting the free run.
    always_comb begin
        logic [RW-1:0] r;
        r       = run_reg;
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < 8; i++) begin
            if (!hit) begin
                if (cur_byte[i]) begin
                    r = '0;
                end else begin
                    r = r + 1'b1;
                    if (r == size_reg) begin
                        hit     = 1'b1;
                        hit_pos = 3'(i);
                    end
                end
            end
        end
        run_after = r;
    end

    always_comb begin
        end_slot   = {word_reg, byte_reg, hit_pos};
        first_slot = end_slot + 1'b1 - SLOT_W'(size_reg);
        mark_lo    = (word_reg == first_reg[SLOT_W-1:6]) ? first_reg[5:0] : 6'd0;
        mark_hi    = (word_reg == end_reg[SLOT_W-1:6]) ? end_reg[5:0] : 6'd63;
        mark_mask  = ({WB{1'b1}} << mark_lo) & ({WB{1'b1}} >> (6'd63 - mark_hi));
        first_ext  = FW'(first_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fca_pkg::ST_CLEAR: begin
                if (last_word) state_next = fca_pkg::ST_IDLE;
            end
            fca_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = req_bad ? fca_pkg::ST_RESP : fca_pkg::ST_RD;
            end
            fca_pkg::ST_RD: begin
                state_next = fca_pkg::ST_CHECK;
            end
            fca_pkg::ST_CHECK: begin
                if (all_used || skip_word) begin
                    state_next = last_word ? fca_pkg::ST_RESP : fca_pkg::ST_RD;
                end else begin
                    state_next = fca_pkg::ST_SCAN;
                end
            end
            fca_pkg::ST_SCAN: begin
                if (hit) begin
                    state_next = fca_pkg::ST_MARK_RD;
                end else if (byte_reg == 3'd7) begin
                    state_next = last_word ? fca_pkg::ST_RESP : fca_pkg::ST_RD;
                end
            end
            fca_pkg::ST_MARK_RD: begin
                state_next = fca_pkg::ST_MARK_WR;
            end
            fca_pkg::ST_MARK_WR: begin
                state_next = (word_reg == end_reg[SLOT_W-1:6]) ? fca_pkg::ST_RESP
                                                                : fca_pkg::ST_MARK_RD;
            end
            fca_pkg::ST_RESP: begin
                if (out_free) state_next = fca_pkg::ST_IDLE;
            end
            default: begin
                state_next = fca_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = '0;
        case (state_reg)
            fca_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
            end
            fca_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            fca_pkg::ST_RD, fca_pkg::ST_MARK_RD: begin
                mem_re = 1'b1;
            end
            fca_pkg::ST_MARK_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_q | mark_mask;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[word_reg] <= mem_wdata;
        if (mem_re) mem_q <= mem[word_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fca_pkg::ST_CLEAR;
            word_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == fca_pkg::ST_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                fca_pkg::ST_CLEAR: begin
                    word_reg <= last_word ? '0 : word_reg + 1'b1;
                end
                fca_pkg::ST_IDLE: begin
                    word_reg  <= '0;
                    byte_reg  <= '0;
                    run_reg   <= '0;
                    size_reg  <= s_tdata[RW-1:0];
                    grant_reg <= 1'b0;
                end
                fca_pkg::ST_CHECK: begin
                    byte_reg <= '0;
                    if (all_used) begin
                        run_reg  <= '0;
                        word_reg <= word_reg + 1'b1;
                    end else if (skip_word) begin
                        run_reg  <= run_plus[RW-1:0];
                        word_reg <= word_reg + 1'b1;
                    end
                end
                fca_pkg::ST_SCAN: begin
                    run_reg  <= run_after;
                    byte_reg <= byte_reg + 1'b1;
                    if (hit) begin
                        grant_reg <= 1'b1;
                        first_reg <= first_slot;
                        end_reg   <= end_slot;
                        word_reg  <= first_slot[SLOT_W-1:6];
                    end else if (byte_reg == 3'd7) begin
                        word_reg <= word_reg + 1'b1;
                    end
                end
                fca_pkg::ST_MARK_WR: begin
                    word_reg <= word_reg + 1'b1;
                end
                fca_pkg::ST_RESP: begin
                    if (out_free) begin
                        m_tuser_reg  <= grant_reg;
                        m_tdata_reg  <= grant_reg ? 16'(first_ext[fca_pkg::START_W-1:0])
                                                  : 16'd0;
                    end
                end
                default: begin
                    word_reg <= word_reg;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`include "assert_macros.svh"

    `FCA_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready,
        state_reg != fca_pkg::ST_IDLE)
    `FCA_ASSERT_IMP(a_run_below_size, aclk, aresetn,
        state_reg == fca_pkg::ST_CHECK || state_reg == fca_pkg::ST_SCAN,
        run_reg < size_reg)
    `FCA_ASSERT_IMP(a_mark_in_run, aclk, aresetn, state_reg == fca_pkg::ST_MARK_WR,
        word_reg >= first_reg[SLOT_W-1:6] && word_reg <= end_reg[SLOT_W-1:6])
    `FCA_ASSERT_IMP(a_grant_ordered, aclk, aresetn,
        state_reg == fca_pkg::ST_RESP && grant_reg, first_reg <= end_reg)

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit contiguous slot allocator.
// ----------------------------------------------------------------------------
// Requests are queued by a stimulus process and offered in bursts with random
// gaps. Each accepted request is run through a bitmap model of the allocator
// kept in the bench, and the grant it predicts is compared with the next
// result item. A directed opening covers zero-length, oversized and
// word-boundary runs. Random batches follow, sized from the space still free
// so the map fills gradually. The run closes by asking for all free slots,
// filling the map if they form one run, and probes it. The receiver stalls
// in shifting patterns and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int REQ_W          = fca_pkg::REQ_W;
    localparam int START_W        = fca_pkg::START_W;
    localparam int MAP_SLOTS      = fca_pkg::SLOTS_DEFAULT;
    localparam int BATCHES        = 10;
    localparam int BATCH_ITEMS    = 105;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 4000;
    localparam int END_WAIT       = 3000;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] start_slot;
    } grant_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    logic [REQ_W-1:0] pending_sizes [$];
    grant_t           grant_q [$];
    bit               occ_map [MAP_SLOTS];
    int               slots_free = MAP_SLOTS;

    logic        in_taken;
    int unsigned tx_burst;
    int unsigned tx_gap;
    rx_mode_t    rx_mode;
    int unsigned rx_mode_left;
    int unsigned rx_tick;
    int unsigned hold_left;
    bit          hold_done;

    int unsigned results_seen;
    int unsigned requests_seen;
    int unsigned grants;
    int unsigned refusals;
    int unsigned zero_reqs;
    int unsigned oversize_reqs;
    int unsigned mismatches;
    int unsigned idle_cycles;

    first_fit_contiguous_allocator #(
        .SLOTS(MAP_SLOTS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Lowest run of free slots of the given length, marked used when found.
    function automatic grant_t allocate_run(input logic [REQ_W-1:0] size);
        grant_t      res;
        int unsigned free_len;
        int unsigned base;
        res      = '0;
        free_len = 0;
        if (size == 0 || size > MAP_SLOTS) begin
            return res;
        end
        for (int s = 0; s < MAP_SLOTS; s++) begin
            if (occ_map[s]) begin
                free_len = 0;
            end else begin
                free_len++;
                if (free_len == size) begin
                    base = s + 1 - size;
                    for (int k = base; k <= s; k++) begin
                        occ_map[k] = 1'b1;
                    end
                    slots_free    -= size;
                    res.granted    = 1'b1;
                    res.start_slot = base[START_W-1:0];
                    return res;
                end
            end
        end
        return res;
    endfunction

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_sizes.size() != 0 || s_tvalid || grant_q.size() != 0);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_burst <= 0;
            tx_gap   <= 0;
        end else if (!s_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (pending_sizes.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, pending_sizes.pop_front()};
                if (tx_burst <= 1) begin
                    tx_burst <= $urandom_range(1, 16);
                    tx_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    tx_burst <= tx_burst - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            rx_mode      <= RX_OPEN;
            rx_mode_left <= 0;
            rx_tick      <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                m_tready  <= 1'b0;
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      <= rx_mode_t'($urandom_range(0, 3));
                    rx_mode_left <= $urandom_range(50, 400);
                end else begin
                    rx_mode_left <= rx_mode_left - 1;
                end
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (rx_tick[2:0] != 3'b101);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : monitor
        grant_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (grant_q.size() == 0) begin
                    mismatches++;
                    $error("unexpected result item: granted %0d start_slot %0d",
                           m_tuser, m_tdata);
                end else begin
                    want = grant_q.pop_front();
                    if (want.granted) grants++;
                    else refusals++;
                    if (m_tuser !== want.granted) begin
                        mismatches++;
                        $error("granted: expected %0d, got %0d", want.granted, m_tuser);
                    end
                    if (m_tdata !== {2'b00, want.start_slot}) begin
                        mismatches++;
                        $error("start_slot: expected %0d, got %0d",
                               want.start_slot, m_tdata);
                    end
                end
            end
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                requests_seen++;
                if (s_tdata[REQ_W-1:0] == 0) zero_reqs++;
                if (s_tdata[REQ_W-1:0] > MAP_SLOTS) oversize_reqs++;
                grant_q.push_back(allocate_run(s_tdata[REQ_W-1:0]));
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("first_fit_contiguous_allocator verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned free_start;
        int unsigned mean;
        int unsigned pick;
        int unsigned size;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        pending_sizes = '{15'd1, 15'd0, 15'd32767, 15'd16385, 15'd16384, 15'd63,
                          15'd64, 15'd1, 15'd65, 15'd127, 15'd128, 15'd129,
                          15'd8, 15'd7, 15'd9};
        wait_drained();

        for (int b = 0; b < BATCHES; b++) begin
            free_start = slots_free;
            mean       = free_start / (BATCHES - b + 1) / 90;
            if (mean == 0) mean = 1;
            repeat (BATCH_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) size = 0;
                else if (pick < 9) size = $urandom_range(MAP_SLOTS + 1, 32767);
                else if (pick < 12 && free_start < MAP_SLOTS)
                    size = $urandom_range(free_start + 1, MAP_SLOTS);
                else if (pick < 20) size = $urandom_range(1, 64);
                else size = $urandom_range(1, 2 * mean);
                pending_sizes.push_back(size[REQ_W-1:0]);
            end
            wait_drained();
        end

        // Ask for all free slots at once, filling the map if they form one run, then probe it.
        free_start = slots_free;
        if (free_start > 0) begin
            pending_sizes.push_back(REQ_W'(free_start + 1));
            pending_sizes.push_back(REQ_W'(free_start));
        end
        pending_sizes.push_back(15'd1);
        pending_sizes.push_back(15'd16384);
        pending_sizes.push_back(15'd0);
        pending_sizes.push_back(REQ_W'($urandom_range(1, 32767)));
        wait_drained();
        repeat (END_WAIT) @(posedge aclk);

        $display("Run covered %0d requests: %0d granted, %0d refused.",
                 requests_seen, grants, refusals);
        $display("Of these %0d asked for nothing and %0d exceeded the map; %0d slots stay free.",
                 zero_reqs, oversize_reqs, slots_free);
        if (mismatches == 0) begin
            $display("first_fit_contiguous_allocator verification clean");
        end else begin
            $display("first_fit_contiguous_allocator verification failed");
        end
        $finish;
    end

endmodule
